// File: sv/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator package
// Token and status codes, the controller state type and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

   // Token kinds on req_func.
   localparam logic [2:0] FN_PUSH = 3'd0;
   localparam logic [2:0] FN_ADD  = 3'd1;
   localparam logic [2:0] FN_SUB  = 3'd2;
   localparam logic [2:0] FN_MUL  = 3'd3;
   localparam logic [2:0] FN_DIV  = 3'd4;
   localparam logic [2:0] FN_END  = 3'd5;

   // Completion status codes on rsp_status.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FEW      = 3'd1;
   localparam logic [2:0] ST_UNKNOWN  = 3'd2;
   localparam logic [2:0] ST_STRUCT   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // Data word and divider iteration count.
   localparam int WORD_W    = 32;
   localparam int DIV_STEPS = 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPER,
      S_MUL,
      S_DIV,
      S_DIVWR
   } state_type;

   typedef struct packed {
      logic       push;
      logic       pop_read;
      logic       wr_add;
      logic       wr_sub;
      logic       mul_start;
      logic       mul_wr;
      logic       div_start;
      logic       div_step;
      logic       div_wr;
      logic       div_zero_wr;
      logic       emit;
      logic       emit_ok;
      logic [2:0] emit_status;
      logic       emit_dz;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic count_ge2;
      logic full;
      logic b_zero;
      logic div_last;
   } stat_type;

endpackage

// File: sv/rpn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator controller
// Decodes tokens, keeps the sticky error code and division flag, sequences
// the datapath through each operator and owns the result valid flag.
// ----------------------------------------------------------------------------
module rpn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_func,
   input  logic              rsp_stall,
   input  rpn_pkg::stat_type stat,
   output rpn_pkg::cmd_type  cmd,
   output logic              req_stall,
   output logic              rsp_valid
);
   import rpn_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [2:0] err_ff, err_in;
   logic       dz_ff, dz_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic       is_op;
   logic       start_op;

   // Tokens wait while busy; an end mark also while the result is stalled.
   assign req_stall = (state_ff != S_IDLE) ||
                      (rsp_valid_ff && rsp_stall && (req_func == FN_END));
   assign accept    = req_valid && !req_stall;
   assign is_op     = (req_func >= FN_ADD) && (req_func <= FN_DIV);
   assign start_op  = accept && (err_ff == ST_OK) && is_op && stat.count_ge2;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= FN_ADD;
         err_ff       <= ST_OK;
         dz_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         err_ff       <= err_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start_op) state_in = S_OPER;
         end
         S_OPER: begin
            unique case (op_ff)
               FN_MUL:  state_in = S_MUL;
               FN_DIV:  state_in = stat.b_zero ? S_IDLE : S_DIV;
               default: state_in = S_IDLE;
            endcase
         end
         S_MUL: state_in = S_IDLE;
         S_DIV: begin
            if (stat.div_last) state_in = S_DIVWR;
         end
         S_DIVWR: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and flag updates.
   always_comb begin
      cmd          = '0;
      op_in        = op_ff;
      err_in       = err_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FN_END) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_ok     = (err_ff == ST_OK) && stat.count_one;
                  cmd.emit_status = (err_ff != ST_OK) ? err_ff :
                                    (stat.count_one ? ST_OK : ST_STRUCT);
                  cmd.emit_dz     = dz_ff;
                  cmd.clear       = 1'b1;
                  err_in          = ST_OK;
                  dz_in           = 1'b0;
                  rsp_valid_in    = 1'b1;
               end else if (err_ff != ST_OK) begin
                  // Tokens after an error are dropped until the end mark.
               end else if (req_func == FN_PUSH) begin
                  if (stat.full) err_in = ST_OVERFLOW;
                  else cmd.push = 1'b1;
               end else if (!is_op) begin
                  err_in = ST_UNKNOWN;
               end else if (!stat.count_ge2) begin
                  err_in = ST_FEW;
               end else begin
                  cmd.pop_read = 1'b1;
                  op_in        = req_func;
               end
            end
         end
         S_OPER: begin
            unique case (op_ff)
               FN_ADD: cmd.wr_add = 1'b1;
               FN_SUB: cmd.wr_sub = 1'b1;
               FN_MUL: cmd.mul_start = 1'b1;
               FN_DIV: begin
                  if (stat.b_zero) begin
                     cmd.div_zero_wr = 1'b1;
                     dz_in           = 1'b1;
                  end else begin
                     cmd.div_start = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_MUL:   cmd.mul_wr = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_DIVWR: cmd.div_wr = 1'b1;
         default: ;
      endcase
   end

endmodule

// File: sv/rpn_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator datapath
// Operand stack (top in a register, the rest in a memory), saturating adder,
// multiplier, radix-2 serial divider and the result register.
// ----------------------------------------------------------------------------
module rpn_dpath #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rpn_pkg::cmd_type         cmd,
   input  logic signed [31:0]       req_operand_value,
   output rpn_pkg::stat_type        stat,
   output logic signed [31:0]       rsp_result_value,
   output logic [2:0]               rsp_status,
   output logic                     rsp_div_by_zero_seen
);
   import rpn_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic signed [WORD_W-1:0] MAX_VAL = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] MIN_VAL = {1'b1, {(WORD_W-1){1'b0}}};

   function automatic logic signed [WORD_W-1:0] sat33(input logic [WORD_W:0] v);
      logic signed [WORD_W-1:0] r;
      if (v[WORD_W] != v[WORD_W-1]) r = v[WORD_W] ? MIN_VAL : MAX_VAL;
      else r = v[WORD_W-1:0];
      return r;
   endfunction

   // Stack storage: entries below the top live in the memory.
   logic signed [WORD_W-1:0] mem [STACK_DEPTH];
   logic signed [WORD_W-1:0] rd_ff;
   logic signed [WORD_W-1:0] tos_ff, tos_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            below_top;
   logic [CW-1:0]            second;

   // Arithmetic.
   logic [WORD_W:0]            sum33, diff33;
   logic signed [2*WORD_W-1:0] prod_ff, prod_in;
   logic signed [2*WORD_W-1:0] mq;
   logic signed [WORD_W-1:0]   mul_res;

   // Divider.
   logic [WORD_W-1:0]   a_mag, b_mag;
   logic [2*WORD_W-1:0] num_mag;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   quo_ff, quo_in;
   logic [WORD_W-1:0]   dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic                sat_ff, sat_in;
   logic [4:0]          step_ff, step_in;
   logic [WORD_W:0]     trial;
   logic                ge;
   logic signed [WORD_W-1:0] div_res;

   // Result register.
   logic signed [WORD_W-1:0] res_ff;
   logic [2:0]               status_ff;
   logic                     dz_ff;

   assign below_top = count_ff - CW'(1);
   assign second    = count_ff - CW'(2);

   assign stat.count_zero = (count_ff == '0);
   assign stat.count_one  = (count_ff == CW'(1));
   assign stat.count_ge2  = (count_ff >= CW'(2));
   assign stat.full       = (count_ff == CW'(STACK_DEPTH));
   assign stat.b_zero     = (tos_ff == '0);
   assign stat.div_last   = (step_ff == 5'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.push && !stat.count_zero) mem[below_top[AW-1:0]] <= tos_ff;
      if (cmd.pop_read) rd_ff <= mem[second[AW-1:0]];
   end

   // Add and subtract use the left operand from memory and the top register.
   assign sum33  = {rd_ff[WORD_W-1], rd_ff} + {tos_ff[WORD_W-1], tos_ff};
   assign diff33 = {rd_ff[WORD_W-1], rd_ff} - {tos_ff[WORD_W-1], tos_ff};

   assign prod_in = (2*WORD_W)'(rd_ff) * (2*WORD_W)'(tos_ff);
   // The arithmetic shift floors, as required for negative products.
   assign mq      = prod_ff >>> FRAC_BITS;
   assign mul_res = ((&mq[2*WORD_W-1:WORD_W-1]) || !(|mq[2*WORD_W-1:WORD_W-1])) ?
                    mq[WORD_W-1:0] : (mq[2*WORD_W-1] ? MIN_VAL : MAX_VAL);

   assign a_mag   = rd_ff[WORD_W-1] ? (~rd_ff + WORD_W'(1)) : rd_ff;
   assign b_mag   = tos_ff[WORD_W-1] ? (~tos_ff + WORD_W'(1)) : tos_ff;
   assign num_mag = {{WORD_W{1'b0}}, a_mag} << FRAC_BITS;

   // One quotient bit per cycle, restoring form.
   assign trial = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, dvs_ff};
   assign ge    = !trial[WORD_W];

   // A quotient of 2^32 or more was flagged up front; the rest saturates here.
   always_comb begin
      if (neg_ff) begin
         if (sat_ff || (quo_ff > {1'b1, {(WORD_W-1){1'b0}}})) div_res = MIN_VAL;
         else div_res = ~quo_ff + WORD_W'(1);
      end else begin
         if (sat_ff || quo_ff[WORD_W-1]) div_res = MAX_VAL;
         else div_res = quo_ff;
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      step_in = step_ff;
      if (cmd.div_start) begin
         rem_in  = num_mag[2*WORD_W-1:WORD_W];
         quo_in  = num_mag[WORD_W-1:0];
         dvs_in  = b_mag;
         neg_in  = rd_ff[WORD_W-1] ^ tos_ff[WORD_W-1];
         sat_in  = (num_mag[2*WORD_W-1:WORD_W] >= b_mag);
         step_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = ge ? trial[WORD_W-1:0] : {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
         quo_in  = {quo_ff[WORD_W-2:0], ge};
         step_in = step_ff + 5'd1;
      end
   end

   always_comb begin
      tos_in   = tos_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         tos_in   = req_operand_value;
         count_in = count_ff + CW'(1);
      end else if (cmd.wr_add || cmd.wr_sub || cmd.mul_wr || cmd.div_wr ||
                   cmd.div_zero_wr) begin
         count_in = count_ff - CW'(1);
         if (cmd.wr_add) tos_in = sat33(sum33);
         else if (cmd.wr_sub) tos_in = sat33(diff33);
         else if (cmd.mul_wr) tos_in = mul_res;
         else if (cmd.div_wr) tos_in = div_res;
         else tos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff  <= tos_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      step_ff <= step_in;
      if (cmd.mul_start) prod_ff <= prod_in;
      if (cmd.emit) begin
         res_ff    <= cmd.emit_ok ? tos_ff : '0;
         status_ff <= cmd.emit_status;
         dz_ff     <= cmd.emit_dz;
      end
   end

   assign rsp_result_value     = res_ff;
   assign rsp_status           = status_ff;
   assign rsp_div_by_zero_seen = dz_ff;

endmodule

// File: sv/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Evaluates reverse Polish expressions of signed fixed-point tokens and
// returns one result with a status for every end mark.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  req      in   req_valid/stall    req_func, req_operand_value
//  rsp      out  rsp_valid/stall    rsp_result_value, rsp_status,
//                                   rsp_div_by_zero_seen
//
// Push, end mark and ignored tokens finish in idle; add and subtract also
// pass the operand state, multiply the operand and multiply states (the
// multiplier output is registered before the shift and clamp). Divide runs
// the operand, serial divider and write states; a zero divisor ends it early.
// Synchronous reset clears the count, error and flags; stack memory is not
// cleared. A held result does not block tokens other than the next end mark.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_div_by_zero_seen
);
   import rpn_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   rpn_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_operand_value    (req_operand_value),
      .stat                 (stat),
      .rsp_result_value     (rsp_result_value),
      .rsp_status           (rsp_status),
      .rsp_div_by_zero_seen (rsp_div_by_zero_seen)
   );

endmodule

// File: sv/rpn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator checker
// Port-level properties of the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rpn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_result_value,
   input logic [2:0]         rsp_status,
   input logic               rsp_div_by_zero_seen
);
   import rpn_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) &&
                                 $stable(rsp_status) && $stable(rsp_div_by_zero_seen))
      else $error("stalled result changed");

   // Any error status carries a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_result_value == '0)
      else $error("nonzero value with error status");

   // A new result only follows a transfer of an end mark.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_xfer && (req_func == FN_END)))
      else $error("result without end mark");

   // Any other token never produces a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_func != FN_END) && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result after non-end token");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_func             (req_func),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_result_value     (rsp_result_value),
   .rsp_status           (rsp_status),
   .rsp_div_by_zero_seen (rsp_div_by_zero_seen)
);
